FILE: src/sstf_pkg.sv
// ----------------------------------------------------------------------------
// SSTF scheduler package
// Shared widths, codes and word types of the shortest-seek-first scheduler.
// ----------------------------------------------------------------------------
package sstf_pkg;

  localparam int DEF_QUEUE_DEPTH    = 16;
  localparam int DEF_MAX_REQUESTERS = 16;
  localparam int DEF_TRACK_BITS     = 16;

  localparam int REQ_W       = 4;
  localparam int TRK_FIELD_W = 16;
  localparam int CFG_W       = 5;
  localparam int CFG_IDX_W   = 1;
  localparam int LIVE_W      = 5;
  localparam int MAX_RESULTS = 16;
  localparam int RES_W       = 5;

  localparam logic [CFG_W-1:0]  MAXQ_RESET = CFG_W'(16);
  localparam logic [LIVE_W-1:0] LIVE_RESET = LIVE_W'(16);

  localparam logic [CFG_IDX_W-1:0] REG_MAX_QUEUE      = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_NUM_REQUESTERS = CFG_IDX_W'(1);

  typedef enum logic {
    OP_ENQUEUE = 1'b0,
    OP_LEAVE   = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    STATUS_SERVED = 2'd0,
    STATUS_FULL   = 2'd1,
    STATUS_BUSY   = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_LOAD  = 2'd1,
    CELL_SHIFT = 2'd2
  } cell_op_e;

  typedef struct packed {
    cell_op_e          op;
    logic [REQ_W-1:0]  owner;
    logic              final_mark;
  } cell_cmd_t;

  typedef struct packed {
    op_e                    op;
    logic [REQ_W-1:0]       requester;
    logic [TRK_FIELD_W-1:0] track;
    logic                   final_request;
  } req_t;

  typedef struct packed {
    status_e                status;
    logic [REQ_W-1:0]       served_requester;
    logic [TRK_FIELD_W-1:0] served_track;
    logic                   last_of_run;
    logic                   all_done;
  } rsp_t;

endpackage

FILE: src/sstf_stream_if.sv
// ----------------------------------------------------------------------------
// SSTF stream interface
// Valid/ready channel carrying one word of a generic payload type.
// ----------------------------------------------------------------------------
interface sstf_stream_if #(
  parameter type data_t = logic
) ();

  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

FILE: src/sstf_cell.sv
// ----------------------------------------------------------------------------
// SSTF queue cell
// Holds one queue entry and one stage of the nearest-track scan token.
// ----------------------------------------------------------------------------
module sstf_cell import sstf_pkg::*; #(
  parameter int  TRACK_BITS  = DEF_TRACK_BITS,
  parameter int  QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int  CELL_INDEX  = 0,
  localparam int TW          = TRACK_BITS,
  localparam int IW          = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
  localparam int CW          = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cell_cmd_t        cmd_i,
  input  logic [IW-1:0]    sel_idx_i,
  input  logic [TW-1:0]    new_track_i,
  input  logic [CW-1:0]    count_i,
  input  logic [TW-1:0]    head_i,
  input  logic [TW-1:0]    nxt_track_i,
  input  logic [REQ_W-1:0] nxt_owner_i,
  input  logic             nxt_final_i,
  output logic [TW-1:0]    own_track_o,
  output logic [REQ_W-1:0] own_owner_o,
  output logic             own_final_o,
  input  logic             scan_found_i,
  input  logic [TW-1:0]    scan_dist_i,
  input  logic [IW-1:0]    scan_idx_i,
  input  logic [TW-1:0]    scan_track_i,
  input  logic [REQ_W-1:0] scan_owner_i,
  input  logic             scan_final_i,
  output logic             scan_found_o,
  output logic [TW-1:0]    scan_dist_o,
  output logic [IW-1:0]    scan_idx_o,
  output logic [TW-1:0]    scan_track_o,
  output logic [REQ_W-1:0] scan_owner_o,
  output logic             scan_final_o
);

  localparam bit HAS_NEXT = (CELL_INDEX + 1) < QUEUE_DEPTH;

  logic [TW-1:0]    track_q;
  logic [REQ_W-1:0] owner_q;
  logic             final_q;

  logic             found_q;
  logic [TW-1:0]    dist_q;
  logic [IW-1:0]    idx_q;
  logic [TW-1:0]    btrack_q;
  logic [REQ_W-1:0] bowner_q;
  logic             bfinal_q;

  logic          occupied;
  logic [TW-1:0] seek_dist;
  logic          take;
  logic          hit_sel;
  logic          in_shift;

  always_comb begin
    occupied  = 32'(count_i) > CELL_INDEX;
    seek_dist = (track_q >= head_i) ? (track_q - head_i) : (head_i - track_q);
    // Later entries win ties, so an equal distance replaces the token.
    take      = occupied && (!scan_found_i || (seek_dist <= scan_dist_i));
    hit_sel   = sel_idx_i == IW'(CELL_INDEX);
    in_shift  = HAS_NEXT && (32'(sel_idx_i) <= CELL_INDEX);
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      CELL_LOAD: begin
        if (hit_sel) begin
          track_q <= new_track_i;
          owner_q <= cmd_i.owner;
          final_q <= cmd_i.final_mark;
        end
      end
      CELL_SHIFT: begin
        if (in_shift) begin
          track_q <= nxt_track_i;
          owner_q <= nxt_owner_i;
          final_q <= nxt_final_i;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else begin
      found_q <= take || scan_found_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      dist_q   <= seek_dist;
      idx_q    <= IW'(CELL_INDEX);
      btrack_q <= track_q;
      bowner_q <= owner_q;
      bfinal_q <= final_q;
    end else begin
      dist_q   <= scan_dist_i;
      idx_q    <= scan_idx_i;
      btrack_q <= scan_track_i;
      bowner_q <= scan_owner_i;
      bfinal_q <= scan_final_i;
    end
  end

  assign own_track_o  = track_q;
  assign own_owner_o  = owner_q;
  assign own_final_o  = final_q;
  assign scan_found_o = found_q;
  assign scan_dist_o  = dist_q;
  assign scan_idx_o   = idx_q;
  assign scan_track_o = btrack_q;
  assign scan_owner_o = bowner_q;
  assign scan_final_o = bfinal_q;

endmodule

FILE: src/sstf_ctrl.sv
// ----------------------------------------------------------------------------
// SSTF scheduler controller
// Admission checks, live count, head position, scan sequencing and output word.
// ----------------------------------------------------------------------------
module sstf_ctrl import sstf_pkg::*; #(
  parameter int  QUEUE_DEPTH    = DEF_QUEUE_DEPTH,
  parameter int  MAX_REQUESTERS = DEF_MAX_REQUESTERS,
  parameter int  TRACK_BITS     = DEF_TRACK_BITS,
  localparam int TW             = TRACK_BITS,
  localparam int IW             = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
  localparam int CW             = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  sstf_stream_if.sink          req_i,
  sstf_stream_if.source        rsp_o,
  output cell_cmd_t            cmd_o,
  output logic [IW-1:0]        sel_idx_o,
  output logic [TW-1:0]        new_track_o,
  output logic [CW-1:0]        count_o,
  output logic [TW-1:0]        head_o,
  input  logic                 best_found_i,
  input  logic [IW-1:0]        best_idx_i,
  input  logic [TW-1:0]        best_track_i,
  input  logic [REQ_W-1:0]     best_owner_i,
  input  logic                 best_final_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_REJECT,
    S_CHECK,
    S_SCAN,
    S_SERVE
  } state_e;

  state_e                    state_q;
  logic [CW-1:0]             count_q;
  logic [LIVE_W-1:0]         live_q;
  logic [TW-1:0]             head_q;
  logic [CFG_W-1:0]          maxq_q;
  logic [MAX_REQUESTERS-1:0] busy_q;
  logic [RES_W-1:0]          nres_q;
  logic [IW-1:0]             timer_q;
  req_t                      item_q;
  status_e                   rej_status_q;
  logic                      out_valid_q;
  rsp_t                      out_data_q;

  logic              out_free;
  logic              out_set;
  logic              accept;
  logic              full;
  logic              busy_rej;
  logic              do_insert;
  logic              serve;
  logic [LIVE_W-1:0] live_dec;
  logic [CW-1:0]     cnt_after;
  logic [LIVE_W-1:0] live_after;
  logic [RES_W-1:0]  nres_inc;

  function automatic logic drain_cond(input logic [CW-1:0]     cnt,
                                      input logic [LIVE_W-1:0] live,
                                      input logic [RES_W-1:0]  nres,
                                      input logic [CFG_W-1:0]  maxq);
    int unsigned thr;
    thr = 32'(maxq);
    if (32'(live) < thr) thr = 32'(live);
    if (32'(QUEUE_DEPTH) < thr) thr = 32'(QUEUE_DEPTH);
    return (cnt != '0) && (32'(cnt) >= thr) && (32'(nres) < 32'(MAX_RESULTS));
  endfunction

  always_comb begin
    out_free = !out_valid_q || rsp_o.ready;
    accept   = (state_q == S_IDLE) && req_i.valid;
    full     = (32'(count_q) >= 32'(maxq_q)) || (32'(count_q) >= 32'(QUEUE_DEPTH));
    busy_rej = 32'(req_i.data.requester) >= 32'(MAX_REQUESTERS);
    for (int unsigned r = 0; r < MAX_REQUESTERS; r++) begin
      if (32'(req_i.data.requester) == r) busy_rej = busy_q[r];
    end
    do_insert  = accept && (req_i.data.op == OP_ENQUEUE) && !full && !busy_rej;
    serve      = (state_q == S_SERVE) && out_free;
    out_set    = ((state_q == S_REJECT) && out_free) || serve;
    live_dec   = (live_q == '0) ? live_q : (live_q - LIVE_W'(1));
    cnt_after  = count_q - CW'(1);
    live_after = best_final_i ? live_dec : live_q;
    nres_inc   = nres_q + RES_W'(1);

    cmd_o.op         = CELL_HOLD;
    cmd_o.owner      = req_i.data.requester;
    cmd_o.final_mark = req_i.data.final_request;
    sel_idx_o        = '0;
    if (do_insert) begin
      cmd_o.op  = CELL_LOAD;
      sel_idx_o = count_q[IW-1:0];
    end else if (serve) begin
      cmd_o.op  = CELL_SHIFT;
      sel_idx_o = best_idx_i;
    end
  end

  assign new_track_o = TW'(req_i.data.track);
  assign count_o     = count_q;
  assign head_o      = head_q;
  assign req_i.ready = state_q == S_IDLE;
  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      live_q       <= LIVE_RESET;
      head_q       <= '0;
      maxq_q       <= MAXQ_RESET;
      busy_q       <= '0;
      nres_q       <= '0;
      timer_q      <= '0;
      item_q       <= '0;
      rej_status_q <= STATUS_FULL;
      out_valid_q  <= 1'b0;
      out_data_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_MAX_QUEUE:      maxq_q <= cfg_data_i;
          REG_NUM_REQUESTERS: live_q <= cfg_data_i;
          default: begin
          end
        endcase
      end

      // A new word may be placed in the same cycle the previous one leaves.
      if (out_set) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          nres_q <= '0;
          if (accept) begin
            item_q  <= req_i.data;
            state_q <= S_CHECK;
            if (req_i.data.op == OP_ENQUEUE) begin
              if (full) begin
                rej_status_q <= STATUS_FULL;
                state_q      <= S_REJECT;
              end else if (busy_rej) begin
                rej_status_q <= STATUS_BUSY;
                state_q      <= S_REJECT;
              end else begin
                count_q <= count_q + CW'(1);
                for (int unsigned r = 0; r < MAX_REQUESTERS; r++) begin
                  if (32'(req_i.data.requester) == r) busy_q[r] <= 1'b1;
                end
              end
            end else begin
              live_q <= live_dec;
            end
          end
        end
        S_REJECT: begin
          if (out_free) begin
            out_data_q.status           <= rej_status_q;
            out_data_q.served_requester <= item_q.requester;
            out_data_q.served_track     <= TRK_FIELD_W'(TW'(item_q.track));
            out_data_q.last_of_run      <= !drain_cond(count_q, live_q, nres_inc, maxq_q);
            out_data_q.all_done         <= (live_q == '0) && (count_q == '0);
            nres_q                      <= nres_inc;
            state_q                     <= S_CHECK;
          end
        end
        S_CHECK: begin
          timer_q <= '0;
          state_q <= drain_cond(count_q, live_q, nres_q, maxq_q) ? S_SCAN : S_IDLE;
        end
        S_SCAN: begin
          // The timer holds this state until the token has passed every cell of the row.
          if (timer_q == IW'(QUEUE_DEPTH - 1)) begin
            state_q <= S_SERVE;
          end else begin
            timer_q <= timer_q + IW'(1);
          end
        end
        S_SERVE: begin
          if (out_free) begin
            head_q  <= best_track_i;
            live_q  <= live_after;
            count_q <= cnt_after;
            nres_q  <= nres_inc;
            for (int unsigned r = 0; r < MAX_REQUESTERS; r++) begin
              if (32'(best_owner_i) == r) busy_q[r] <= 1'b0;
            end
            out_data_q.status           <= STATUS_SERVED;
            out_data_q.served_requester <= best_owner_i;
            out_data_q.served_track     <= TRK_FIELD_W'(best_track_i);
            out_data_q.last_of_run      <= !drain_cond(cnt_after, live_after, nres_inc,
                                                       maxq_q);
            out_data_q.all_done         <= (live_after == '0) && (cnt_after == '0);
            state_q                     <= S_CHECK;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Every queued entry belongs to exactly one busy requester.
  a_busy_matches_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(busy_q) == 32'(count_q))
    else $error("busy flags disagree with queue occupancy");

  a_serve_has_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SERVE) |-> (best_found_i && (count_q != '0)))
    else $error("serving without a scanned entry");

  a_serve_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    serve |=> (count_q == $past(count_q) - CW'(1)))
    else $error("queue did not shrink after a serve");

  a_results_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(nres_q) <= 32'(MAX_RESULTS))
    else $error("too many result words for one input word");

endmodule

FILE: src/sstf_disk_request_scheduler_top.sv
// ----------------------------------------------------------------------------
// SSTF disk request scheduler, top level
// Row of queue cells with a travelling nearest-track scan token, and controller.
//
//   channel  dir  word   accepted when
//   req_i    in   req_t  req_i.valid && req_i.ready
//   rsp_o    out  rsp_t  rsp_o.valid && rsp_o.ready
//   cfg      in   5 bit  cfg_we_i high, register selected by cfg_idx_i
//
// An input word passes the idle and check states, reject when it is rejected,
// and scan and serve for every request it serves; the scan token walks the
// whole cell row once per served request. One input word is handled at a time.
// Reset is asynchronous and needs no clearing pass; queue entries are only
// read below the fill count. A stalled rsp_o holds its word, and the block
// waits for the output register before it places the next word.
// ----------------------------------------------------------------------------
module sstf_disk_request_scheduler_top import sstf_pkg::*; #(
  parameter int QUEUE_DEPTH    = DEF_QUEUE_DEPTH,
  parameter int MAX_REQUESTERS = DEF_MAX_REQUESTERS,
  parameter int TRACK_BITS     = DEF_TRACK_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  sstf_stream_if.sink          req_i,
  sstf_stream_if.source        rsp_o
);

  localparam int TW = TRACK_BITS;
  localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cell_cmd_t     cmd;
  logic [IW-1:0] sel_idx;
  logic [TW-1:0] new_track;
  logic [CW-1:0] count;
  logic [TW-1:0] head;

  logic [TW-1:0]    own_track [QUEUE_DEPTH];
  logic [REQ_W-1:0] own_owner [QUEUE_DEPTH];
  logic             own_final [QUEUE_DEPTH];
  logic [TW-1:0]    nxt_track [QUEUE_DEPTH];
  logic [REQ_W-1:0] nxt_owner [QUEUE_DEPTH];
  logic             nxt_final [QUEUE_DEPTH];

  logic             scan_found [QUEUE_DEPTH+1];
  logic [TW-1:0]    scan_dist  [QUEUE_DEPTH+1];
  logic [IW-1:0]    scan_idx   [QUEUE_DEPTH+1];
  logic [TW-1:0]    scan_track [QUEUE_DEPTH+1];
  logic [REQ_W-1:0] scan_owner [QUEUE_DEPTH+1];
  logic             scan_final [QUEUE_DEPTH+1];

  // The token enters the row empty at cell zero.
  assign scan_found[0] = 1'b0;
  assign scan_dist[0]  = '0;
  assign scan_idx[0]   = '0;
  assign scan_track[0] = '0;
  assign scan_owner[0] = '0;
  assign scan_final[0] = 1'b0;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    if (i + 1 < QUEUE_DEPTH) begin : g_nxt
      assign nxt_track[i] = own_track[i+1];
      assign nxt_owner[i] = own_owner[i+1];
      assign nxt_final[i] = own_final[i+1];
    end else begin : g_end
      assign nxt_track[i] = '0;
      assign nxt_owner[i] = '0;
      assign nxt_final[i] = 1'b0;
    end

    sstf_cell #(
      .TRACK_BITS  (TRACK_BITS),
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .CELL_INDEX  (i)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .sel_idx_i    (sel_idx),
      .new_track_i  (new_track),
      .count_i      (count),
      .head_i       (head),
      .nxt_track_i  (nxt_track[i]),
      .nxt_owner_i  (nxt_owner[i]),
      .nxt_final_i  (nxt_final[i]),
      .own_track_o  (own_track[i]),
      .own_owner_o  (own_owner[i]),
      .own_final_o  (own_final[i]),
      .scan_found_i (scan_found[i]),
      .scan_dist_i  (scan_dist[i]),
      .scan_idx_i   (scan_idx[i]),
      .scan_track_i (scan_track[i]),
      .scan_owner_i (scan_owner[i]),
      .scan_final_i (scan_final[i]),
      .scan_found_o (scan_found[i+1]),
      .scan_dist_o  (scan_dist[i+1]),
      .scan_idx_o   (scan_idx[i+1]),
      .scan_track_o (scan_track[i+1]),
      .scan_owner_o (scan_owner[i+1]),
      .scan_final_o (scan_final[i+1])
    );
  end

  sstf_ctrl #(
    .QUEUE_DEPTH    (QUEUE_DEPTH),
    .MAX_REQUESTERS (MAX_REQUESTERS),
    .TRACK_BITS     (TRACK_BITS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .req_i        (req_i),
    .rsp_o        (rsp_o),
    .cmd_o        (cmd),
    .sel_idx_o    (sel_idx),
    .new_track_o  (new_track),
    .count_o      (count),
    .head_o       (head),
    .best_found_i (scan_found[QUEUE_DEPTH]),
    .best_idx_i   (scan_idx[QUEUE_DEPTH]),
    .best_track_i (scan_track[QUEUE_DEPTH]),
    .best_owner_i (scan_owner[QUEUE_DEPTH]),
    .best_final_i (scan_final[QUEUE_DEPTH])
  );

endmodule

FILE: verif/sstf_disk_request_scheduler_top_tb.sv
// ----------------------------------------------------------------------------
// SSTF disk request scheduler testbench
// Drives request words into the scheduler and checks every result word against
// a shortest-seek predictor kept in step with the accepted requests. A short
// table of directed words comes first, then random phases under several
// register settings, with input and output idling and a long output stall.
// ----------------------------------------------------------------------------
module sstf_disk_request_scheduler_top_tb;
  import sstf_pkg::*;

  localparam int QDEPTH      = DEF_QUEUE_DEPTH;
  localparam int NREQ_MAX    = DEF_MAX_REQUESTERS;
  localparam int SETTLE      = 2 * (QDEPTH + 2) + 4;
  localparam int TAIL        = MAX_RESULTS * (QDEPTH + 3) + 16;
  localparam int LIMIT       = 500000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_WORDS = 11;
  localparam int NUM_PHASES  = 7;

  typedef enum logic {
    ROW_CFG,
    ROW_WORD
  } row_kind_e;

  typedef struct {
    row_kind_e            kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     val;
    req_t                 word;
    bit                   typed;
    rsp_t                 want;
  } stim_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_data;

  sstf_stream_if #(.data_t(req_t)) req_if ();
  sstf_stream_if #(.data_t(rsp_t)) rsp_if ();

  sstf_disk_request_scheduler_top u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  always #6 clk = ~clk;

  // Predictor state: queue entries in insertion order, busy flags, live count.
  logic [TRK_FIELD_W-1:0] pq_track [QDEPTH];
  logic [REQ_W-1:0]       pq_owner [QDEPTH];
  logic                   pq_final [QDEPTH];
  int                     pq_count = 0;
  bit                     pr_busy [NREQ_MAX];
  int                     pr_live = 16;
  logic [TRK_FIELD_W-1:0] pr_head = '0;
  int                     pr_maxq = 16;

  rsp_t due_words [$];
  rsp_t step_words [$];
  rsp_t seen_word;
  rsp_t due_word;

  int send_idle = 0;
  int recv_idle = 0;
  int hold_reqs = 0;
  int holds_done = 0;
  int hold_left = 0;
  int cycles = 0;
  int mismatches = 0;
  int words_sent = 0;
  int words_checked = 0;
  int reg_writes = 0;
  int results_predicted = 0;

  int ph_maxq [NUM_PHASES] = '{16, 1, 4, 16, 8, 3, 16};
  int ph_nreq [NUM_PHASES] = '{16, 5, 16, 0, 3, 8, 16};

  function automatic int min_of(input int a, input int b);
    return (a < b) ? a : b;
  endfunction

  function automatic void post_word(input status_e st, input logic [REQ_W-1:0] who,
                                    input logic [TRK_FIELD_W-1:0] trk);
    rsp_t r;
    r.status           = st;
    r.served_requester = who;
    r.served_track     = trk;
    r.last_of_run      = 1'b0;
    r.all_done         = (pr_live == 0 && pq_count == 0);
    step_words = {step_words, r};
  endfunction

  // Handles one request word, then serves the nearest track, up to MAX_RESULTS
  // words, while the nonempty queue holds at least min(max_queue, live count, QDEPTH) entries.
  function automatic void sstf_serve(input req_t w);
    int best;
    int best_d;
    int d;
    int i;
    logic [TRK_FIELD_W-1:0] t;
    logic [REQ_W-1:0]       o;
    logic                   f;
    step_words.delete();
    if (w.op == OP_ENQUEUE) begin
      if (pq_count >= pr_maxq || pq_count >= QDEPTH) begin
        post_word(STATUS_FULL, w.requester, w.track);
      end else if (pr_busy[w.requester]) begin
        post_word(STATUS_BUSY, w.requester, w.track);
      end else begin
        pq_track[pq_count] = w.track;
        pq_owner[pq_count] = w.requester;
        pq_final[pq_count] = w.final_request;
        pq_count++;
        pr_busy[w.requester] = 1'b1;
      end
    end else if (pr_live > 0) begin
      pr_live--;
    end
    while (pq_count > 0 && pq_count >= min_of(min_of(pr_maxq, pr_live), QDEPTH) &&
           step_words.size() < MAX_RESULTS) begin
      best   = 0;
      best_d = 0;
      for (i = 0; i < pq_count; i++) begin
        d = int'(pq_track[i]) - int'(pr_head);
        if (d < 0) d = -d;
        // Ties go to the later entry, so the newest request wins.
        if (i == 0 || d <= best_d) begin
          best   = i;
          best_d = d;
        end
      end
      t = pq_track[best];
      o = pq_owner[best];
      f = pq_final[best];
      pr_head    = t;
      pr_busy[o] = 1'b0;
      if (f && pr_live > 0) pr_live--;
      for (i = best; i + 1 < pq_count; i++) begin
        pq_track[i] = pq_track[i + 1];
        pq_owner[i] = pq_owner[i + 1];
        pq_final[i] = pq_final[i + 1];
      end
      pq_count--;
      post_word(STATUS_SERVED, o, t);
    end
    if (step_words.size() > 0) begin
      step_words[step_words.size() - 1].last_of_run = 1'b1;
    end
  endfunction

  function automatic req_t draw_word();
    req_t w;
    int   idle_ids [$];
    int   k;
    int   pick;
    for (k = 0; k < NREQ_MAX; k++) begin
      if (!pr_busy[k]) idle_ids = {idle_ids, k};
    end
    w.op = ($urandom_range(99) < 12) ? OP_LEAVE : OP_ENQUEUE;
    if (idle_ids.size() > 0 && $urandom_range(99) < 80) begin
      w.requester = REQ_W'(idle_ids[$urandom_range(idle_ids.size() - 1)]);
    end else begin
      w.requester = REQ_W'($urandom_range(NREQ_MAX - 1));
    end
    pick = $urandom_range(9);
    if (pick == 0) begin
      w.track = ($urandom_range(1) == 0) ? '0 : '1;
    end else if (pick == 1) begin
      w.track = ($urandom_range(1) == 0) ? 16'h8000 : 16'h7FFF;
    end else if (pick <= 4) begin
      // Tracks close to the head give equal distances on both sides.
      w.track = pr_head + TRK_FIELD_W'($urandom_range(6)) - TRK_FIELD_W'(3);
    end else begin
      w.track = TRK_FIELD_W'($urandom_range(65535));
    end
    w.final_request = ($urandom_range(99) < 15);
    return w;
  endfunction

  function automatic stim_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx, input int val);
    stim_row_t r;
    r.kind  = ROW_CFG;
    r.idx   = idx;
    r.val   = CFG_W'(val);
    r.word  = '0;
    r.typed = 1'b0;
    r.want  = '0;
    return r;
  endfunction

  function automatic stim_row_t req_row(input op_e op, input int who, input int trk,
                                        input bit fin);
    stim_row_t r;
    r.kind               = ROW_WORD;
    r.idx                = '0;
    r.val                = '0;
    r.word.op            = op;
    r.word.requester     = REQ_W'(who);
    r.word.track         = TRK_FIELD_W'(trk);
    r.word.final_request = fin;
    r.typed              = 1'b0;
    r.want               = '0;
    return r;
  endfunction

  // An enqueue whose single result word is known in advance.
  function automatic stim_row_t chk_row(input int who, input int trk, input bit fin,
                                        input status_e st, input bit done);
    stim_row_t r;
    r = req_row(OP_ENQUEUE, who, trk, fin);
    r.typed                 = 1'b1;
    r.want.status           = st;
    r.want.served_requester = REQ_W'(who);
    r.want.served_track     = TRK_FIELD_W'(trk);
    r.want.last_of_run      = 1'b1;
    r.want.all_done         = done;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatches < 40) begin
      $display("MISMATCH @%0d: %s got %0d want %0d", cycles, what, got, want);
    end
    mismatches++;
  endtask

  task automatic wait_idle();
    req_if.valid <= 1'b0;
    while (due_words.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= CFG_W'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == REG_MAX_QUEUE) begin
      pr_maxq = val;
    end else begin
      pr_live = val;
    end
    reg_writes++;
  endtask

  task automatic send_word(input req_t w, input bit typed, input rsp_t want);
    while ($urandom_range(99) < send_idle) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= w;
    do @(posedge clk); while (req_if.ready !== 1'b1);
    sstf_serve(w);
    words_sent++;
    results_predicted += step_words.size();
    if (typed) begin
      due_words = {due_words, want};
    end else begin
      due_words = {due_words, step_words};
    end
  endtask

  // Output side: random stalls, plus a long hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      rsp_if.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (hold_reqs != holds_done) begin
      rsp_if.ready <= 1'b0;
      hold_left    <= HOLD_CYCLES;
      holds_done   <= holds_done + 1;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    if (rst_n && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      seen_word = rsp_if.data;
      words_checked++;
      if (due_words.size() == 0) begin
        report_mismatch("word with nothing due, requester", seen_word.served_requester, -1);
      end else begin
        due_word = due_words.pop_front();
        if (seen_word.status !== due_word.status)
          report_mismatch("status", seen_word.status, due_word.status);
        if (seen_word.served_requester !== due_word.served_requester)
          report_mismatch("served_requester", seen_word.served_requester,
                          due_word.served_requester);
        if (seen_word.served_track !== due_word.served_track)
          report_mismatch("served_track", seen_word.served_track, due_word.served_track);
        if (seen_word.last_of_run !== due_word.last_of_run)
          report_mismatch("last_of_run", seen_word.last_of_run, due_word.last_of_run);
        if (seen_word.all_done !== due_word.all_done)
          report_mismatch("all_done", seen_word.all_done, due_word.all_done);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("sstf_disk_request_scheduler_top_tb: done, errors");
      $finish;
    end
  end

  initial begin
    stim_row_t dir_rows [$];
    int        p;
    int        n;
    req_if.valid = 1'b0;
    req_if.data  = '0;
    rsp_if.ready = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = '0;
    cfg_data     = '0;

    dir_rows = {dir_rows, cfg_row(REG_MAX_QUEUE, 1)};
    dir_rows = {dir_rows, chk_row(0, 16'hFFFF, 1'b0, STATUS_SERVED, 1'b0)};
    dir_rows = {dir_rows, chk_row(15, 0, 1'b1, STATUS_SERVED, 1'b0)};
    dir_rows = {dir_rows, req_row(OP_LEAVE, 3, 16'h5A5A, 1'b1)};
    dir_rows = {dir_rows, cfg_row(REG_MAX_QUEUE, 16)};
    dir_rows = {dir_rows, cfg_row(REG_NUM_REQUESTERS, 3)};
    dir_rows = {dir_rows, req_row(OP_ENQUEUE, 1, 100, 1'b0)};
    dir_rows = {dir_rows, chk_row(1, 200, 1'b0, STATUS_BUSY, 1'b0)};
    dir_rows = {dir_rows, req_row(OP_ENQUEUE, 2, 50, 1'b1)};
    dir_rows = {dir_rows, req_row(OP_ENQUEUE, 4, 50, 1'b0)};
    dir_rows = {dir_rows, req_row(OP_LEAVE, 7, 0, 1'b0)};
    dir_rows = {dir_rows, cfg_row(REG_MAX_QUEUE, 2)};
    dir_rows = {dir_rows, cfg_row(REG_NUM_REQUESTERS, 16)};
    dir_rows = {dir_rows, req_row(OP_ENQUEUE, 5, 1000, 1'b0)};
    dir_rows = {dir_rows, req_row(OP_ENQUEUE, 6, 3000, 1'b0)};
    dir_rows = {dir_rows, chk_row(6, 5, 1'b1, STATUS_BUSY, 1'b0)};
    dir_rows = {dir_rows, req_row(OP_ENQUEUE, 7, 3000, 1'b0)};
    // Lowering max_queue to the fill level makes the next enqueue overflow.
    dir_rows = {dir_rows, cfg_row(REG_MAX_QUEUE, 1)};
    dir_rows = {dir_rows, req_row(OP_ENQUEUE, 8, 77, 1'b0)};
    dir_rows = {dir_rows, cfg_row(REG_MAX_QUEUE, 16)};
    dir_rows = {dir_rows, cfg_row(REG_NUM_REQUESTERS, 2)};
    dir_rows = {dir_rows, req_row(OP_ENQUEUE, 12, 9, 1'b1)};
    dir_rows = {dir_rows, req_row(OP_ENQUEUE, 13, 16'h8000, 1'b1)};
    dir_rows = {dir_rows, req_row(OP_LEAVE, 0, 16'hFFFF, 1'b0)};
    dir_rows = {dir_rows, chk_row(3, 1234, 1'b0, STATUS_SERVED, 1'b1)};
    dir_rows = {dir_rows, cfg_row(REG_NUM_REQUESTERS, 0)};
    dir_rows = {dir_rows, chk_row(9, 16'hFFFF, 1'b1, STATUS_SERVED, 1'b1)};
    dir_rows = {dir_rows, cfg_row(REG_NUM_REQUESTERS, 4)};
    dir_rows = {dir_rows, req_row(OP_ENQUEUE, 1, 10, 1'b0)};
    dir_rows = {dir_rows, req_row(OP_LEAVE, 1, 0, 1'b0)};
    dir_rows = {dir_rows, req_row(OP_ENQUEUE, 2, 20, 1'b0)};
    dir_rows = {dir_rows, req_row(OP_ENQUEUE, 3, 30, 1'b1)};

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    send_idle = 8;
    recv_idle <= 67;

    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == ROW_CFG) begin
        wait_idle();
        write_reg(dir_rows[r].idx, dir_rows[r].val);
      end else begin
        send_word(dir_rows[r].word, dir_rows[r].typed, dir_rows[r].want);
      end
    end

    p = 0;
    while (p < NUM_PHASES) begin
      wait_idle();
      if (p < 3) begin
        send_idle = 8;
        recv_idle <= 67;
      end else if (p < 5) begin
        send_idle = 67;
        recv_idle <= 8;
      end else begin
        send_idle = 0;
        recv_idle <= 0;
      end
      write_reg(REG_MAX_QUEUE, ph_maxq[p]);
      write_reg(REG_NUM_REQUESTERS, ph_nreq[p]);
      // With max_queue at one every enqueue answers, so a long output stall
      // backs the block up into its input.
      if (p == 1) hold_reqs <= hold_reqs + 1;
      for (n = 0; n < PHASE_WORDS; n++) begin
        if (p == 4 && n == 7) wait_idle();
        send_word(draw_word(), 1'b0, '0);
      end
      p++;
    end

    req_if.valid <= 1'b0;
    while (due_words.size() != 0) @(posedge clk);
    repeat (TAIL) @(posedge clk);

    $display("Run summary: %0d request words, %0d register writes, %0d of %0d words checked.",
             words_sent, reg_writes, words_checked, results_predicted);
    $display("Exercised full and busy rejects, seek ties, multi-word drains, stalled output.");
    if (mismatches == 0) begin
      $display("sstf_disk_request_scheduler_top_tb: done, clean");
    end else begin
      $display("sstf_disk_request_scheduler_top_tb: done, errors");
    end
    $finish;
  end

endmodule
